@@ design/hxd_pkg.sv @@
package hxd_pkg;

    // Frame limits.
    localparam int DATA_MAX  = 1024;
    localparam int FRAME_MAX = 8192;

    // Counter widths follow from the limits.
    localparam int CC_W = $clog2(FRAME_MAX + 1);
    localparam int DC_W = $clog2(DATA_MAX + 1);

    // Fixed field widths of the result.
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int SECTOR_W = 16;

    // Characters that the framing uses.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_HEADER    = 3'd1,
        ST_SECTOR_RANGE = 3'd2,
        ST_BYTE_OVF     = 3'd3,
        ST_FRAME_OVF    = 3'd4
    } status_t;

    typedef enum logic {
        CFG_SECTOR_MIN = 1'b0,
        CFG_SECTOR_MAX = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                is_status;
        logic [7:0]          decoded_byte;
        logic [INDEX_W-1:0]  byte_index;
        status_t             status_code;
        logic [SECTOR_W-1:0] sector_number;
        logic [COUNT_W-1:0]  byte_count;
        logic                last;
    } result_t;

    // Results of one transfer: an optional data byte, then an optional status.
    typedef struct packed {
        logic    push_data;
        logic    push_status;
        result_t data_res;
        result_t status_res;
    } push_t;

    // Hex digit value in five-bit two's complement; a non-hex character is -1.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
            end else if (c >= CH_LA && c <= CH_LF) begin
                d = c - CH_LA + 8'd10;
            end else if (c >= CH_UA && c <= CH_UF) begin
                d = c - CH_UA + 8'd10;
            end else begin
                d = 8'hFF;
            end
            return d[4:0];
        end
    endfunction

    // 16*hi + lo, taken modulo 65536.
    function automatic logic [15:0] pair_val(input logic [7:0] hi, input logic [7:0] lo);
        logic [4:0]  hv;
        logic [4:0]  lv;
        logic [15:0] hx;
        logic [15:0] lx;
        begin
            hv = hex_val(hi);
            lv = hex_val(lo);
            hx = {{11{hv[4]}}, hv};
            lx = {{11{lv[4]}}, lv};
            return (hx << 4) + lx;
        end
    endfunction

endpackage

@@ design/hxd_if.sv @@
interface hxd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       frame_end;

    modport source (output valid, output char_in, output frame_end, input ready);
    modport sink   (input valid, input char_in, input frame_end, output ready);
endinterface

interface hxd_out_if;
    logic        valid;
    logic        ready;
    logic        is_status;
    logic [7:0]  decoded_byte;
    logic [9:0]  byte_index;
    logic [2:0]  status_code;
    logic [15:0] sector_number;
    logic [10:0] byte_count;
    logic        last;

    modport source (output valid, output is_status, output decoded_byte, output byte_index,
                    output status_code, output sector_number, output byte_count,
                    output last, input ready);
    modport sink   (input valid, input is_status, input decoded_byte, input byte_index,
                    input status_code, input sector_number, input byte_count,
                    input last, output ready);
endinterface

@@ design/hxd_core.sv @@
module hxd_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [7:0]         char_in,
    input  logic               frame_end,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    output hxd_pkg::push_t     push
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_DATA,
        PH_STOP
    } phase_t;

    logic [39:0]               recent_reg, recent_next;
    phase_t                    phase_reg, phase_next;
    logic [2:0]                tblock_reg, tblock_next;
    logic [hxd_pkg::CC_W-1:0]  cc_reg, cc_next;
    logic [hxd_pkg::DC_W-1:0]  dc_reg, dc_next;
    logic [15:0]               sector_reg, sector_next;
    hxd_pkg::status_t          fault_reg, fault_next;
    logic [15:0]               smin_reg, smax_reg;

    logic [47:0]               win;
    logic [7:0]                c0, c1, c2, c3, c4, c5;
    logic [15:0]               hdr_val;
    logic                      emit;
    hxd_pkg::status_t          code;

    function automatic logic [7:0] hdr_pair_byte(input logic [7:0] hi, input logic [7:0] lo);
        logic [15:0] v;
        begin
            v = hxd_pkg::pair_val(hi, lo);
            return v[7:0];
        end
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            smin_reg <= 16'd0;
            smax_reg <= 16'hFFFF;
        end else if (cfg_we) begin
            case (hxd_pkg::cfg_index_t'(cfg_index))
                hxd_pkg::CFG_SECTOR_MIN: smin_reg <= cfg_data;
                hxd_pkg::CFG_SECTOR_MAX: smax_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Character window including the new character.
    assign win     = {recent_reg, char_in};
    assign c0      = win[7:0];
    assign c1      = win[15:8];
    assign c2      = win[23:16];
    assign c3      = win[31:24];
    assign c4      = win[39:32];
    assign c5      = win[47:40];
    assign hdr_val = hxd_pkg::pair_val(c2, c1);

    // Frame decoding for one transfer.
    always_comb
    begin
        recent_next = win[39:0];
        phase_next  = phase_reg;
        tblock_next = tblock_reg;
        cc_next     = cc_reg;
        dc_next     = dc_reg;
        sector_next = sector_reg;
        fault_next  = fault_reg;
        emit        = 1'b0;
        code        = hxd_pkg::ST_OK;

        if (cc_reg < hxd_pkg::CC_W'(hxd_pkg::FRAME_MAX)) begin
            cc_next = cc_reg + 1'b1;
        end
        if (cc_next >= hxd_pkg::CC_W'(hxd_pkg::FRAME_MAX)) begin
            fault_next = hxd_pkg::ST_FRAME_OVF;
            phase_next = PH_STOP;
        end

        case (phase_next)
            PH_HUNT:
            begin
                if (c5 == hxd_pkg::CH_DOLLAR && c4 == hxd_pkg::CH_ZERO &&
                    c3 == hxd_pkg::CH_X && c0 == hxd_pkg::CH_DOLLAR) begin
                    sector_next = hdr_val;
                    if (hdr_val >= smin_reg && hdr_val <= smax_reg) begin
                        phase_next  = PH_DATA;
                        tblock_next = 3'd3;
                    end else begin
                        fault_next = hxd_pkg::ST_SECTOR_RANGE;
                        phase_next = PH_STOP;
                    end
                end
            end
            PH_DATA:
            begin
                if (tblock_reg != 3'd0) begin
                    tblock_next = tblock_reg - 3'd1;
                end else if (c3 == hxd_pkg::CH_ZERO && c2 == hxd_pkg::CH_X) begin
                    if (dc_reg < hxd_pkg::DC_W'(hxd_pkg::DATA_MAX)) begin
                        emit        = 1'b1;
                        dc_next     = dc_reg + 1'b1;
                        tblock_next = 3'd4;
                    end else begin
                        fault_next = hxd_pkg::ST_BYTE_OVF;
                        phase_next = PH_STOP;
                    end
                end
            end
            default: ;
        endcase

        // Closing status: a fault wins, then a missing header.
        if (fault_next != hxd_pkg::ST_OK) begin
            code = fault_next;
        end else if (phase_next == PH_HUNT) begin
            code = hxd_pkg::ST_NO_HEADER;
        end

        push.push_data                = fire && emit;
        push.push_status              = fire && frame_end;
        push.data_res.is_status       = 1'b0;
        push.data_res.decoded_byte    = hdr_pair_byte(c1, c0);
        push.data_res.byte_index      = hxd_pkg::INDEX_W'(dc_reg);
        push.data_res.status_code     = hxd_pkg::ST_OK;
        push.data_res.sector_number   = sector_reg;
        push.data_res.byte_count      = '0;
        push.data_res.last            = 1'b0;
        push.status_res.is_status     = 1'b1;
        push.status_res.decoded_byte  = 8'd0;
        push.status_res.byte_index    = '0;
        push.status_res.status_code   = code;
        push.status_res.sector_number = sector_next;
        push.status_res.byte_count    = hxd_pkg::COUNT_W'(dc_next);
        push.status_res.last          = 1'b1;

        // The status ends the frame and clears its state.
        if (frame_end) begin
            recent_next = 40'd0;
            phase_next  = PH_HUNT;
            tblock_next = 3'd0;
            cc_next     = '0;
            dc_next     = '0;
            sector_next = 16'd0;
            fault_next  = hxd_pkg::ST_OK;
        end
    end

    // Frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            recent_reg <= 40'd0;
            phase_reg  <= PH_HUNT;
            tblock_reg <= 3'd0;
            cc_reg     <= '0;
            dc_reg     <= '0;
            sector_reg <= 16'd0;
            fault_reg  <= hxd_pkg::ST_OK;
        end else if (fire) begin
            recent_reg <= recent_next;
            phase_reg  <= phase_next;
            tblock_reg <= tblock_next;
            cc_reg     <= cc_next;
            dc_reg     <= dc_next;
            sector_reg <= sector_next;
            fault_reg  <= fault_next;
        end
    end

    // The byte counter never passes its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        dc_reg <= hxd_pkg::DC_W'(hxd_pkg::DATA_MAX))
        else $error("data count above limit");

    // Decoding only runs while no fault is recorded.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> fault_reg == hxd_pkg::ST_OK)
        else $error("decoding with a fault recorded");

    // A status transfer leaves a cleared frame behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.push_status |=> cc_reg == '0 && dc_reg == '0 && phase_reg == PH_HUNT)
        else $error("frame state not cleared after status");

endmodule

@@ design/hxd_fifo.sv @@
module hxd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  hxd_pkg::push_t   push,
    output logic             has_room,
    output logic             out_valid,
    input  logic             out_ready,
    output hxd_pkg::result_t out_res
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hxd_pkg::result_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         n_push;
    logic               pop;
    hxd_pkg::result_t   first_res;

    // Room is kept for the two results one character can cause.
    assign has_room  = cnt_reg <= CNT_W'(DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_res   = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = {1'b0, push.push_data} + {1'b0, push.push_status};
    assign first_res = push.push_data ? push.data_res : push.status_res;

    always_comb
    begin
        wr_next  = wr_reg + PTR_W'(n_push);
        rd_next  = rd_reg + PTR_W'(pop);
        cnt_next = cnt_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    // Result storage, written in transfer order.
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0) begin
            mem[wr_reg] <= first_res;
        end
        if (n_push == 2'd2) begin
            mem[wr_reg + PTR_W'(1)] <= push.status_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // The fill level stays within the storage.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("result queue overfilled");

    // Pointers and fill level move together.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[PTR_W-1:0] == wr_reg - rd_reg)
        else $error("result queue pointers disagree with fill level");

    // The fill level follows transfers in and out.
    assert property (@(posedge clk) disable iff (!rst_n)
        ##1 cnt_reg == $past(cnt_reg) + CNT_W'($past(n_push)) - CNT_W'($past(pop)))
        else $error("result queue fill level miscounted");

endmodule

@@ design/hex_text_frame_decoder_top.sv @@
// Hex text frame decoder.
// in_ch carries one text character per transfer, with frame_end marking the
// last character of a frame. out_ch carries results: one data byte with its
// index for each '0xHH' token after a valid '$0xHH$' header, and one status
// transfer (last = 1) closing each frame with the code, sector and byte count.
// The character that closes a frame may give a data byte followed by its status.
// cfg_we / cfg_index / cfg_data write sector_min (index 0) and sector_max
// (index 1); write them only while no frame is in progress.
// Throughput: one character per cycle while the queue has room. The decode is
// a single combinational step from the accepted character and frame state into
// a four-entry result queue; a result is offered on out_ch in the cycle after
// its character at the earliest. in_ch.ready is high while the queue has room
// for two results, so a stalled receiver keeps characters flowing until three
// or more results wait, then input stops; no result is lost. Reset clears the
// frame state, the queue and the sector limits (0 and 65535).
module hex_text_frame_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    hxd_in_if.sink      in_ch,
    hxd_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    hxd_pkg::push_t   push;
    hxd_pkg::result_t res;
    logic             has_room;
    logic             fire;

    assign in_ch.ready = has_room;
    assign fire        = in_ch.valid && has_room;

    // Frame decoding.
    hxd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_in   (in_ch.char_in),
        .frame_end (in_ch.frame_end),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    // Result queue toward the receiver.
    hxd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .has_room  (has_room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (res)
    );

    assign out_ch.is_status     = res.is_status;
    assign out_ch.decoded_byte  = res.decoded_byte;
    assign out_ch.byte_index    = res.byte_index;
    assign out_ch.status_code   = res.status_code;
    assign out_ch.sector_number = res.sector_number;
    assign out_ch.byte_count    = res.byte_count;
    assign out_ch.last          = res.last;

endmodule
